>>> src/indexed_min_heap_queue_unit_assert.svh
// Assertion macros used by the checker.
`ifndef INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH
`define INDEXED_MIN_HEAP_QUEUE_UNIT_ASSERT_SVH

// Check a property while out of reset.
`define IMHQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("imhq assertion failed");

// Check a property at every edge, reset included.
`define IMHQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("imhq assertion failed");

`endif

>>> src/imhq_pkg.sv
package imhq_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = 6;
  localparam int CNT_W    = 7;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 6;
  localparam int ENTRY_W  = KEY_W + HANDLE_W;

  localparam logic [2:0] KIND_INSERT = 3'd0;
  localparam logic [2:0] KIND_RM_HEAD = 3'd1;
  localparam logic [2:0] KIND_PEEK   = 3'd2;
  localparam logic [2:0] KIND_RM_HDL = 3'd3;
  localparam logic [2:0] KIND_UPDATE = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;
  localparam logic [1:0] ST_HANDLE = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [HANDLE_W-1:0] handle;
  } entry_t;

  // True when key a must sit strictly nearer the head than key b.
  function automatic logic precedes(input logic [KEY_W-1:0] a,
                                    input logic [KEY_W-1:0] b,
                                    input logic order);
    precedes = order ? (a > b) : (a < b);
  endfunction

endpackage

>>> src/imhq_ram.sv
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> src/indexed_min_heap_queue_unit.sv
// Indexed binary heap priority queue of up to 64 (key, handle) entries. Each
// input beat is one operation (tuser: insert, remove head, peek head, remove by
// handle, update key) and yields exactly one result beat with a status, the
// removed or peeked entry and the occupancy after the operation. Entries live
// in one heap RAM (key and handle per slot) and one RAM mapping each handle to
// its heap slot; presence of each handle is a flop per handle. The moving entry
// is held in a register while its hole walks the tree. One operation at a time:
// peek and rejected operations only report, insert climbs, remove moves the last
// entry into the victim's slot and sinks then climbs it unless the victim held
// the last slot, and update climbs then sinks. The heap RAM has a single read
// port, one slot a cycle. compare_order (cfg) selects smallest (0) or largest
// (1) key at the head; a result may wait in the output register while the next
// beat is accepted.
module indexed_min_heap_queue_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // new_key[31:0], handle[37:32], zero pad
  input  logic [2:0]  in_tuser,   // kind[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // out_handle[5:0], out_key[37:6], occupancy[44:38]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DISP  = 4'd1;
  localparam logic [3:0] S_RM1   = 4'd2;
  localparam logic [3:0] S_RM2   = 4'd3;
  localparam logic [3:0] S_UPCHK = 4'd4;
  localparam logic [3:0] S_UPCMP = 4'd5;
  localparam logic [3:0] S_DNL   = 4'd6;
  localparam logic [3:0] S_DNR   = 4'd7;
  localparam logic [3:0] S_DNC   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_RLD   = 4'd10;
  localparam logic [3:0] S_RLD2  = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  // What follows the current sift phase.
  localparam logic [1:0] FOL_NONE   = 2'd0;
  localparam logic [1:0] FOL_RELOAD = 2'd1;
  localparam logic [1:0] FOL_DOWN   = 2'd2;

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [imhq_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [imhq_pkg::HANDLE_W-1:0] hdl_r, hdl_nxt;
  imhq_pkg::entry_t cur_r, cur_nxt;
  imhq_pkg::entry_t lch_r, lch_nxt;
  logic [imhq_pkg::ADDR_W-1:0] hole_r, hole_nxt;
  logic [imhq_pkg::ADDR_W-1:0] start_r, start_nxt;
  logic [imhq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [63:0] present_r, present_nxt;
  logic [1:0] follow_r, follow_nxt;
  logic [1:0] st_r, st_nxt;
  logic [imhq_pkg::HANDLE_W-1:0] ohdl_r, ohdl_nxt;
  logic [imhq_pkg::KEY_W-1:0] okey_r, okey_nxt;
  logic order_r;
  logic out_valid_r, out_valid_nxt;
  logic [47:0] out_data_r, out_data_nxt;
  logic [1:0] out_user_r, out_user_nxt;

  logic hp_we, ps_we;
  logic [imhq_pkg::ADDR_W-1:0] hp_waddr, hp_raddr, ps_waddr, ps_raddr;
  imhq_pkg::entry_t hp_wdata, hp_rd;
  logic [imhq_pkg::ENTRY_W-1:0] hp_rdata;
  logic [imhq_pkg::ADDR_W-1:0] ps_wdata, ps_rdata;

  logic live;
  logic [imhq_pkg::CNT_W-1:0] lidx;
  logic [imhq_pkg::CNT_W:0] ridx;
  logic [imhq_pkg::ADDR_W-1:0] parent;
  logic l_first, r_first, l_over_r;

  imhq_ram #(.WIDTH(imhq_pkg::ENTRY_W), .DEPTH(imhq_pkg::CAPACITY)) u_heap_ram (
    .clk  (clk),
    .we   (hp_we),
    .waddr(hp_waddr),
    .wdata(hp_wdata),
    .raddr(hp_raddr),
    .rdata(hp_rdata)
  );

  imhq_ram #(.WIDTH(imhq_pkg::ADDR_W), .DEPTH(64)) u_pos_ram (
    .clk  (clk),
    .we   (ps_we),
    .waddr(ps_waddr),
    .wdata(ps_wdata),
    .raddr(ps_raddr),
    .rdata(ps_rdata)
  );

  assign hp_rd      = imhq_pkg::entry_t'(hp_rdata);
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // Tree arithmetic around the hole.
  assign lidx   = {hole_r, 1'b1};
  assign ridx   = {1'b0, hole_r, 1'b0} + (imhq_pkg::CNT_W+1)'(2);
  assign parent = (hole_r - imhq_pkg::ADDR_W'(1)) >> 1;
  assign live   = present_r[hdl_r] && ({1'b0, ps_rdata} < cnt_r);

  assign l_first  = imhq_pkg::precedes(lch_r.key, cur_r.key, order_r);
  assign r_first  = imhq_pkg::precedes(hp_rd.key, cur_r.key, order_r);
  assign l_over_r = imhq_pkg::precedes(lch_r.key, hp_rd.key, order_r);

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    key_nxt       = key_r;
    hdl_nxt       = hdl_r;
    cur_nxt       = cur_r;
    lch_nxt       = lch_r;
    hole_nxt      = hole_r;
    start_nxt     = start_r;
    cnt_nxt       = cnt_r;
    present_nxt   = present_r;
    follow_nxt    = follow_r;
    st_nxt        = st_r;
    ohdl_nxt      = ohdl_r;
    okey_nxt      = okey_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;
    hp_we         = 1'b0;
    hp_waddr      = hole_r;
    hp_wdata      = cur_r;
    hp_raddr      = '0;
    ps_we         = 1'b0;
    ps_waddr      = cur_r.handle;
    ps_wdata      = hole_r;
    ps_raddr      = in_tdata[37:32];

    case (state_r)
      S_IDLE: begin
        // Fetch the handle's slot and the head while latching the beat.
        if (in_tvalid) begin
          kind_nxt  = in_tuser;
          key_nxt   = in_tdata[31:0];
          hdl_nxt   = in_tdata[37:32];
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        st_nxt     = imhq_pkg::ST_OK;
        ohdl_nxt   = '0;
        okey_nxt   = '0;
        follow_nxt = FOL_NONE;
        state_nxt  = S_OUT;
        case (kind_r)
          imhq_pkg::KIND_INSERT: begin
            if (live) begin
              st_nxt = imhq_pkg::ST_HANDLE;
            end else if (cnt_r == imhq_pkg::CNT_W'(imhq_pkg::CAPACITY)) begin
              st_nxt = imhq_pkg::ST_FULL;
            end else begin
              cur_nxt              = '{key: key_r, handle: hdl_r};
              hole_nxt             = cnt_r[imhq_pkg::ADDR_W-1:0];
              cnt_nxt              = cnt_r + imhq_pkg::CNT_W'(1);
              present_nxt[hdl_r]   = 1'b1;
              state_nxt            = S_UPCHK;
            end
          end
          imhq_pkg::KIND_RM_HEAD: begin
            if (cnt_r == '0) begin
              st_nxt = imhq_pkg::ST_EMPTY;
            end else begin
              start_nxt = '0;
              hp_raddr  = '0;
              state_nxt = S_RM1;
            end
          end
          imhq_pkg::KIND_PEEK: begin
            if (cnt_r == '0) begin
              st_nxt = imhq_pkg::ST_EMPTY;
            end else begin
              okey_nxt = hp_rd.key;
              ohdl_nxt = hp_rd.handle;
            end
          end
          imhq_pkg::KIND_RM_HDL: begin
            if (!live) begin
              st_nxt = imhq_pkg::ST_HANDLE;
            end else begin
              start_nxt = ps_rdata;
              hp_raddr  = ps_rdata;
              state_nxt = S_RM1;
            end
          end
          imhq_pkg::KIND_UPDATE: begin
            if (!live) begin
              st_nxt = imhq_pkg::ST_HANDLE;
            end else begin
              cur_nxt    = '{key: key_r, handle: hdl_r};
              hole_nxt   = ps_rdata;
              follow_nxt = FOL_DOWN;
              state_nxt  = S_UPCHK;
            end
          end
          default: begin
          end
        endcase
      end
      S_RM1: begin
        // Report the victim, drop its handle, fetch the last entry.
        okey_nxt                  = hp_rd.key;
        ohdl_nxt                  = hp_rd.handle;
        present_nxt[hp_rd.handle] = 1'b0;
        cnt_nxt                   = cnt_r - imhq_pkg::CNT_W'(1);
        hp_raddr                  = cnt_nxt[imhq_pkg::ADDR_W-1:0];
        state_nxt                 = S_RM2;
      end
      S_RM2: begin
        if ({1'b0, start_r} == cnt_r) begin
          state_nxt = S_OUT;
        end else begin
          cur_nxt    = hp_rd;
          hole_nxt   = start_r;
          follow_nxt = FOL_RELOAD;
          state_nxt  = S_DNL;
        end
      end
      S_UPCHK: begin
        if (hole_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          hp_raddr  = parent;
          state_nxt = S_UPCMP;
        end
      end
      S_UPCMP: begin
        // Pull the parent down into the hole while the entry beats it.
        if (imhq_pkg::precedes(cur_r.key, hp_rd.key, order_r)) begin
          hp_we     = 1'b1;
          hp_wdata  = hp_rd;
          ps_we     = 1'b1;
          ps_waddr  = hp_rd.handle;
          hole_nxt  = parent;
          state_nxt = S_UPCHK;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DNL: begin
        if (lidx >= cnt_r) begin
          state_nxt = S_FIN;
        end else begin
          hp_raddr  = lidx[imhq_pkg::ADDR_W-1:0];
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        lch_nxt = hp_rd;
        if (ridx >= {1'b0, cnt_r}) begin
          // Only a left child.
          if (imhq_pkg::precedes(hp_rd.key, cur_r.key, order_r)) begin
            hp_we     = 1'b1;
            hp_wdata  = hp_rd;
            ps_we     = 1'b1;
            ps_waddr  = hp_rd.handle;
            hole_nxt  = lidx[imhq_pkg::ADDR_W-1:0];
            state_nxt = S_DNL;
          end else begin
            state_nxt = S_FIN;
          end
        end else begin
          hp_raddr  = ridx[imhq_pkg::ADDR_W-1:0];
          state_nxt = S_DNC;
        end
      end
      S_DNC: begin
        if (!l_first && !r_first) begin
          state_nxt = S_FIN;
        end else begin
          // Ties go to the right child.
          hp_we = 1'b1;
          ps_we = 1'b1;
          if (l_over_r) begin
            hp_wdata = lch_r;
            ps_waddr = lch_r.handle;
            hole_nxt = lidx[imhq_pkg::ADDR_W-1:0];
          end else begin
            hp_wdata = hp_rd;
            ps_waddr = hp_rd.handle;
            hole_nxt = ridx[imhq_pkg::ADDR_W-1:0];
          end
          state_nxt = S_DNL;
        end
      end
      S_FIN: begin
        // Drop the moving entry into its hole.
        hp_we      = 1'b1;
        ps_we      = 1'b1;
        follow_nxt = FOL_NONE;
        case (follow_r)
          FOL_RELOAD: state_nxt = S_RLD;
          FOL_DOWN:   state_nxt = S_DNL;
          default:    state_nxt = S_OUT;
        endcase
      end
      S_RLD: begin
        hp_raddr  = start_r;
        hole_nxt  = start_r;
        state_nxt = S_RLD2;
      end
      S_RLD2: begin
        cur_nxt   = hp_rd;
        state_nxt = S_UPCHK;
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = st_r;
          out_data_nxt  = {3'b000, cnt_r, okey_r, ohdl_r};
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      present_r   <= '0;
      follow_r    <= FOL_NONE;
      out_valid_r <= 1'b0;
      order_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      present_r   <= present_nxt;
      follow_r    <= follow_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        order_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    key_r      <= key_nxt;
    hdl_r      <= hdl_nxt;
    cur_r      <= cur_nxt;
    lch_r      <= lch_nxt;
    hole_r     <= hole_nxt;
    start_r    <= start_nxt;
    st_r       <= st_nxt;
    ohdl_r     <= ohdl_nxt;
    okey_r     <= okey_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

endmodule

>>> src/imhq_chk.sv
`include "indexed_min_heap_queue_unit_assert.svh"

module imhq_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [1:0]  out_tuser
);

  `IMHQ_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> !out_tvalid)
  `IMHQ_ASSERT(a_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
  `IMHQ_ASSERT(a_occ_cap, out_tvalid |-> out_tdata[44:38] <= 7'(imhq_pkg::CAPACITY))
  `IMHQ_ASSERT(a_empty_clean, out_tvalid && out_tuser == imhq_pkg::ST_EMPTY |->
    out_tdata[44:0] == 45'd0)

endmodule

bind indexed_min_heap_queue_unit imhq_chk u_imhq_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tuser (out_tuser)
);

>>> verif/indexed_min_heap_queue_unit_tb.sv
`timescale 1ns / 1ps

module indexed_min_heap_queue_unit_tb;

  // Kinds past update key do nothing and still answer with one beat.
  localparam logic [2:0] KIND_NOP5 = 3'd5;
  localparam logic [2:0] KIND_NOP6 = 3'd6;
  localparam logic [2:0] KIND_NOP7 = 3'd7;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    logic [1:0]                    status;
    logic [imhq_pkg::HANDLE_W-1:0] handle;
    logic [imhq_pkg::KEY_W-1:0]    key;
    logic [imhq_pkg::CNT_W-1:0]    occ;
  } result_t;

  typedef struct {
    logic [2:0]                    kind;
    logic [imhq_pkg::KEY_W-1:0]    key;
    logic [imhq_pkg::HANDLE_W-1:0] handle;
    bit                            typed;
    result_t                       res;
  } op_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // new_key[31:0], handle[37:32], zero pad
  logic [2:0]  in_tuser;   // kind[2:0]
  logic        out_tvalid;
  logic        out_tready;
  logic [47:0] out_tdata;  // out_handle[5:0], out_key[37:6], occupancy[44:38]
  logic [1:0]  out_tuser;  // status[1:0]
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  indexed_min_heap_queue_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // Shadow heap, kept in step with every accepted beat.
  logic [imhq_pkg::KEY_W-1:0]    sh_key  [imhq_pkg::CAPACITY];
  logic [imhq_pkg::HANDLE_W-1:0] sh_hdl  [imhq_pkg::CAPACITY];
  int                            sh_pos  [64];
  bit                            sh_live [64];
  int                            sh_count;
  bit                            sh_order;

  result_t pending_results[$];
  int      send_idle, recv_stall;
  int      errors, beats_in, beats_out;
  bit      hold_req;
  int      hold_left;

  op_row_t directed_ops [21] = '{
    '{imhq_pkg::KIND_PEEK,    32'd0,         6'd0,  1'b1,
      '{imhq_pkg::ST_EMPTY,  6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HEAD, 32'd0,         6'd0,  1'b1,
      '{imhq_pkg::ST_EMPTY,  6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HDL,  32'd0,         6'd5,  1'b1,
      '{imhq_pkg::ST_HANDLE, 6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_UPDATE,  32'd9,         6'd5,  1'b1,
      '{imhq_pkg::ST_HANDLE, 6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_INSERT,  32'd0,         6'd0,  1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd1}},
    '{imhq_pkg::KIND_INSERT,  32'hFFFF_FFFF, 6'd63, 1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd2}},
    '{imhq_pkg::KIND_INSERT,  32'd7,         6'd0,  1'b1,
      '{imhq_pkg::ST_HANDLE, 6'd0, 32'd0, 7'd2}},
    '{imhq_pkg::KIND_INSERT,  32'h8000_0000, 6'd10, 1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_INSERT,  32'd0,         6'd12, 1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_PEEK,    32'd0,         6'd0,  1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd4}},
    '{KIND_NOP5,              32'd1,         6'd1,  1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd4}},
    '{KIND_NOP6,              32'hFFFF_FFFF, 6'd63, 1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd4}},
    '{KIND_NOP7,              32'd0,         6'd12, 1'b1,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd4}},
    '{imhq_pkg::KIND_UPDATE,  32'd1,         6'd63, 1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_UPDATE,  32'hFFFF_FFFF, 6'd0,  1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HDL,  32'd0,         6'd10, 1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HEAD, 32'd0,         6'd0,  1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HEAD, 32'd0,         6'd0,  1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_PEEK,    32'd0,         6'd0,  1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HEAD, 32'd0,         6'd0,  1'b0,
      '{imhq_pkg::ST_OK,     6'd0, 32'd0, 7'd0}},
    '{imhq_pkg::KIND_RM_HEAD, 32'd0,         6'd0,  1'b1,
      '{imhq_pkg::ST_EMPTY,  6'd0, 32'd0, 7'd0}}
  };

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs.
  initial begin
    #5ms;
    $display("%0t: timeout, %0d results still pending", $time, pending_results.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------- heap predictor ----------------

  // True when key a belongs strictly nearer the head than key b.
  function automatic bit nearer(logic [imhq_pkg::KEY_W-1:0] a,
                                logic [imhq_pkg::KEY_W-1:0] b);
    return sh_order ? (a > b) : (a < b);
  endfunction

  function automatic void swap_slots(int x, int y);
    logic [imhq_pkg::KEY_W-1:0]    k;
    logic [imhq_pkg::HANDLE_W-1:0] h;
    k = sh_key[x];  h = sh_hdl[x];
    sh_key[x] = sh_key[y];  sh_hdl[x] = sh_hdl[y];
    sh_key[y] = k;  sh_hdl[y] = h;
    sh_pos[sh_hdl[x]] = x;
    sh_pos[sh_hdl[y]] = y;
  endfunction

  // Climb while strictly nearer than the parent; a tie stops the climb.
  function automatic void climb(int p);
    while (p != 0 && nearer(sh_key[p], sh_key[(p - 1) / 2])) begin
      swap_slots(p, (p - 1) / 2);
      p = (p - 1) / 2;
    end
  endfunction

  // Sink toward the nearer child; on a tie between children take the right.
  function automatic void sink(int p);
    int l, r, pick;
    forever begin
      l = 2 * p + 1;
      r = 2 * p + 2;
      if (l >= sh_count) return;
      if (r >= sh_count) begin
        if (nearer(sh_key[l], sh_key[p])) swap_slots(p, l);
        return;
      end
      if (!nearer(sh_key[l], sh_key[p]) && !nearer(sh_key[r], sh_key[p])) return;
      pick = nearer(sh_key[l], sh_key[r]) ? l : r;
      swap_slots(p, pick);
      p = pick;
    end
  endfunction

  function automatic void take_slot(int p, ref result_t res);
    res.key    = sh_key[p];
    res.handle = sh_hdl[p];
    sh_live[sh_hdl[p]] = 1'b0;
    sh_count--;
    if (sh_count != p) begin
      sh_key[p] = sh_key[sh_count];
      sh_hdl[p] = sh_hdl[sh_count];
      sh_pos[sh_hdl[p]] = p;
      sink(p);
      climb(p);
    end
  endfunction

  function automatic bit is_live(logic [imhq_pkg::HANDLE_W-1:0] h);
    return sh_live[h] && sh_pos[h] < sh_count;
  endfunction

  function automatic result_t apply_op(logic [2:0] kind, logic [imhq_pkg::KEY_W-1:0] key,
                                       logic [imhq_pkg::HANDLE_W-1:0] h);
    result_t res;
    res = '0;
    res.status = imhq_pkg::ST_OK;
    case (kind)
      imhq_pkg::KIND_INSERT: begin
        if (is_live(h)) res.status = imhq_pkg::ST_HANDLE;
        else if (sh_count >= imhq_pkg::CAPACITY) res.status = imhq_pkg::ST_FULL;
        else begin
          sh_key[sh_count] = key;
          sh_hdl[sh_count] = h;
          sh_pos[h] = sh_count;
          sh_live[h] = 1'b1;
          sh_count++;
          climb(sh_count - 1);
        end
      end
      imhq_pkg::KIND_RM_HEAD: begin
        if (sh_count == 0) res.status = imhq_pkg::ST_EMPTY;
        else take_slot(0, res);
      end
      imhq_pkg::KIND_PEEK: begin
        if (sh_count == 0) res.status = imhq_pkg::ST_EMPTY;
        else begin
          res.key    = sh_key[0];
          res.handle = sh_hdl[0];
        end
      end
      imhq_pkg::KIND_RM_HDL: begin
        if (!is_live(h)) res.status = imhq_pkg::ST_HANDLE;
        else take_slot(sh_pos[h], res);
      end
      imhq_pkg::KIND_UPDATE: begin
        if (!is_live(h)) res.status = imhq_pkg::ST_HANDLE;
        else begin
          sh_key[sh_pos[h]] = key;
          climb(sh_pos[h]);
          sink(sh_pos[h]);
        end
      end
      default: ;
    endcase
    res.occ = sh_count[imhq_pkg::CNT_W-1:0];
    return res;
  endfunction

  // ---------------- sender ----------------

  // Offer one beat, idling at random first; hold until accepted, then predict.
  task automatic send_op(logic [2:0] kind, logic [imhq_pkg::KEY_W-1:0] key,
                         logic [imhq_pkg::HANDLE_W-1:0] h,
                         bit typed, result_t typed_res);
    result_t res;
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {2'b00, h, key};
    in_tuser  <= kind;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_in++;
    res = apply_op(kind, key, h);
    if (typed) begin
      if (res !== typed_res) begin
        $display("%0t: predictor disagrees on directed beat: expected %h actual %h",
                 $time, typed_res, res);
        errors++;
      end
      res = typed_res;
    end
    pending_results.push_back(res);
  endtask

  function automatic logic [imhq_pkg::KEY_W-1:0] pick_key();
    case ($urandom_range(3))
      0: return $urandom_range(7);            // crowd the keys to force ties
      1: return $urandom_range(1) ? '1 : '0;
      default: return $urandom;
    endcase
  endfunction

  task automatic send_random(int n);
    int r, ins_share;
    logic [2:0] kind;
    repeat (n) begin
      // Keep the heap populated so removals and updates land on live handles.
      ins_share = (sh_count < 24) ? 45 : 25;
      r = $urandom_range(99);
      if (r < ins_share) kind = imhq_pkg::KIND_INSERT;
      else if (r < ins_share + 18) kind = imhq_pkg::KIND_RM_HEAD;
      else if (r < ins_share + 28) kind = imhq_pkg::KIND_PEEK;
      else if (r < ins_share + 44) kind = imhq_pkg::KIND_RM_HDL;
      else if (r < 96) kind = imhq_pkg::KIND_UPDATE;
      else kind = 3'($urandom_range(KIND_NOP7, KIND_NOP5));
      send_op(kind, pick_key(), 6'($urandom_range(63)), 1'b0, '0);
    end
  endtask

  // Drain everything outstanding, let the block settle, then write the order.
  task automatic set_order(bit order);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (40) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= order;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sh_order = order;
  endtask

  // ---------------- receiver and checker ----------------

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.handle = out_tdata[5:0];
      got.key    = out_tdata[37:6];
      got.occ    = out_tdata[44:38];
      beats_out++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat %h", $time, got);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
          errors++;
        end
        if (got.handle !== want.handle) begin
          $display("%0t: handle expected %0d actual %0d", $time, want.handle, got.handle);
          errors++;
        end
        if (got.key !== want.key) begin
          $display("%0t: key expected %h actual %h", $time, want.key, got.key);
          errors++;
        end
        if (got.occ !== want.occ) begin
          $display("%0t: occupancy expected %0d actual %0d", $time, want.occ, got.occ);
          errors++;
        end
      end
    end
    // Long hold-off first, then random stalls.
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall);
    end
  end

  // ---------------- main sequence ----------------

  initial begin
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = '0;
    out_tready  = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 1'b0;
    send_idle   = 0;
    recv_stall  = 0;
    errors      = 0;
    beats_in    = 0;
    beats_out   = 0;
    hold_req    = 1'b0;
    hold_left   = 0;
    sh_count    = 0;
    sh_order    = 1'b0;
    foreach (sh_live[i]) begin
      sh_live[i] = 1'b0;
      sh_pos[i]  = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty cases, extremes, ties, absent handles, no-op kinds.
    set_order(1'b0);
    foreach (directed_ops[i])
      send_op(directed_ops[i].kind, directed_ops[i].key, directed_ops[i].handle,
              directed_ops[i].typed, directed_ops[i].res);

    // Fill every handle, bounce a duplicate off a full heap, then drain.
    set_order(1'b1);
    for (int h = 0; h < 64; h++) send_op(imhq_pkg::KIND_INSERT, pick_key(), 6'(h), 1'b0, '0);
    send_op(imhq_pkg::KIND_INSERT, 32'd5, 6'd17, 1'b0, '0);
    repeat (66) send_op(imhq_pkg::KIND_RM_HEAD, '0, '0, 1'b0, '0);

    // Random phases across idling patterns and both orders.
    send_random(150);
    set_order(1'b0);
    send_idle = 53;
    send_random(150);
    set_order(1'b1);
    send_idle = 0;
    recv_stall = 53;
    send_random(150);
    set_order(1'b0);
    send_idle = 30;
    recv_stall = 30;
    send_random(100);

    // Back-pressure: receiver stops while the sender keeps offering beats.
    send_idle  = 0;
    recv_stall = 0;
    hold_req   = 1'b1;
    send_random(40);

    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk);

    $display("Ran %0d operation beats, %0d results checked, both head orders,", beats_in,
             beats_out);
    $display("full and empty heaps, ties, absent handles, idle and stall mixes.");
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/imhq_pkg.sv
src/imhq_ram.sv
src/indexed_min_heap_queue_unit.sv
src/imhq_chk.sv
verif/indexed_min_heap_queue_unit_tb.sv
